/* hw/rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache tag store.
package salc_pkg;

    localparam int ADDR_W      = 31;   // access address width
    localparam int STAMP_W     = 32;   // timestamp width (access index)
    localparam int COUNT_W     = 32;   // miss and access counter width
    localparam int WAY_OUT_W   = 3;    // way field of a result
    localparam int IN_TDATA_W  = 32;   // address padded to whole bytes
    localparam int OUT_TDATA_W = 40;   // hit, way, misses padded to whole bytes

    localparam int SETS_REG_W  = 7;
    localparam int WAYS_REG_W  = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [SETS_REG_W-1:0] SETS_RESET = 7'd64;
    localparam logic [WAYS_REG_W-1:0] WAYS_RESET = 4'd8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SETS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'b1;

    // Set selection remainder: eight quotient bits are retired per cycle.
    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W  = 2;

    // One way of a set row as it sits in the tag memory.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOOK,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/salc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/set_assoc_lru_cache_tags.sv */
// Top level of the set-associative cache tag store with LRU replacement.
//
//  Channel   Direction  Signals                              Moves
//  --------  ---------  -----------------------------------  -----------------------------
//  s_axis    in         s_axis_tvalid/tready/tdata[31:0]     one access request (address)
//  m_axis    out        m_axis_tvalid/tready/tdata[39:0]     one result (hit, way, misses)
//  cfg       in         cfg_we, cfg_index, cfg_data[6:0]     register write, no read-back
//
// After acceptance a request passes the set remainder unit (8 address bits per cycle), one
// tag memory read, one lookup, one write-back and the hand-over of the result to the output
// register, which waits while a stalled result still holds that register, before the idle
// state takes the next request. A miss into a full set adds a scan for the oldest timestamp,
// one way a cycle. After reset a clearing pass writes every set row empty, during which no
// request is accepted. A stalled result waits in the output register while the next request
// is already accepted and worked on.
module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [salc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [30:0] address
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [salc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [0] hit, [3:1] way,
                                                                // [35:4] misses
);

    localparam int SETW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAYW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NSW   = $clog2(MAX_SETS + 1);
    localparam int NWW   = $clog2(MAX_WAYS + 1);
    localparam int RW    = NSW + 1;
    localparam int ROW_W = MAX_WAYS * salc_pkg::ENTRY_W;
    localparam int PAD_W = salc_pkg::OUT_TDATA_W - 1 - salc_pkg::WAY_OUT_W
                           - salc_pkg::COUNT_W;

    // Control state
    salc_pkg::state_t                     state_reg, state_next;
    logic [SETW-1:0]                      clr_cnt_reg, clr_cnt_next;
    logic [salc_pkg::DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [salc_pkg::SETS_REG_W-1:0]      sets_reg, sets_next;
    logic [salc_pkg::WAYS_REG_W-1:0]      ways_reg, ways_next;
    logic [salc_pkg::COUNT_W-1:0]         access_reg, access_next;
    logic [salc_pkg::COUNT_W-1:0]         miss_reg, miss_next;
    logic                                 out_valid_reg, out_valid_next;

    // Payload state
    logic [salc_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    logic [salc_pkg::DIV_W-1:0]           div_reg, div_next;
    logic [RW-1:0]                        rem_reg, rem_next;
    salc_pkg::entry_t [MAX_WAYS-1:0]      row_reg, row_next;
    logic                                 hit_reg, hit_next;
    logic [WAYW-1:0]                      chosen_reg, chosen_next;
    logic [WAYW-1:0]                      scan_reg, scan_next;
    logic [salc_pkg::STAMP_W-1:0]         oldest_reg, oldest_next;
    logic [salc_pkg::OUT_TDATA_W-1:0]     out_data_reg, out_data_next;

    // Memory interface
    logic                                 ram_we;
    logic [SETW-1:0]                      ram_waddr;
    logic [ROW_W-1:0]                     ram_wdata;
    logic [ROW_W-1:0]                     ram_rdata;
    salc_pkg::entry_t [MAX_WAYS-1:0]      rd_row;
    salc_pkg::entry_t [MAX_WAYS-1:0]      wr_row;

    // Lookup and helpers
    logic [NSW-1:0]                       nsets;
    logic [NWW-1:0]                       nways;
    logic [RW-1:0]                        rem_step;
    logic                                 look_hit;
    logic [WAYW-1:0]                      look_hit_way;
    logic                                 look_empty;
    logic [WAYW-1:0]                      look_empty_way;
    logic                                 out_free;
    logic                                 scan_last;

    assign rd_row   = ram_rdata;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign scan_last = (NWW'(scan_reg) == nways - NWW'(1));

    // Register values of zero count as one; values above the build limits clamp.
    always_comb
    begin
        if (sets_reg == '0)
        begin
            nsets = NSW'(1);
        end
        else if (32'(sets_reg) > MAX_SETS)
        begin
            nsets = NSW'(MAX_SETS);
        end
        else
        begin
            nsets = NSW'(sets_reg);
        end

        if (ways_reg == '0)
        begin
            nways = NWW'(1);
        end
        else if (32'(ways_reg) > MAX_WAYS)
        begin
            nways = NWW'(MAX_WAYS);
        end
        else
        begin
            nways = NWW'(ways_reg);
        end
    end

    // Restoring remainder: eight address bits, most significant first, per cycle.
    always_comb
    begin
        logic [RW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < salc_pkg::DIV_BITS; i++)
        begin
            r = {r[RW-2:0], div_reg[salc_pkg::DIV_W-1-i]};
            if (r >= {1'b0, nsets})
            begin
                r = r - {1'b0, nsets};
            end
        end
        rem_step = r;
    end

    // Compare all ways in use at once; the lowest way wins on both searches.
    always_comb
    begin
        look_hit       = 1'b0;
        look_hit_way   = '0;
        look_empty     = 1'b0;
        look_empty_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (NWW'(w) < nways)
            begin
                if (!look_hit && rd_row[w].valid && rd_row[w].tag == addr_reg)
                begin
                    look_hit     = 1'b1;
                    look_hit_way = WAYW'(w);
                end
                if (!look_empty && !rd_row[w].valid)
                begin
                    look_empty     = 1'b1;
                    look_empty_way = WAYW'(w);
                end
            end
        end
    end

    // The chosen way takes the address and the current access index. On a hit
    // the tag is rewritten with the same value.
    always_comb
    begin
        wr_row = row_reg;
        wr_row[chosen_reg].valid = 1'b1;
        wr_row[chosen_reg].tag   = addr_reg;
        wr_row[chosen_reg].stamp = access_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == SETW'(MAX_SETS - 1))
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = salc_pkg::ST_DIV;
                end
            end
            salc_pkg::ST_DIV:
            begin
                if (div_cnt_reg == salc_pkg::DIV_CNT_W'(salc_pkg::DIV_STEPS - 1))
                begin
                    state_next = salc_pkg::ST_READ;
                end
            end
            salc_pkg::ST_READ:
            begin
                state_next = salc_pkg::ST_LOOK;
            end
            salc_pkg::ST_LOOK:
            begin
                if (look_hit || look_empty || nways == NWW'(1))
                begin
                    state_next = salc_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = salc_pkg::ST_SCAN;
                end
            end
            salc_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = salc_pkg::ST_WRITE;
                end
            end
            salc_pkg::ST_WRITE:
            begin
                state_next = salc_pkg::ST_FINISH;
            end
            salc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = salc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine: handshake and memory write port.
    // A request is written back before the next one can reach the read state,
    // so reads never overlap a pending write of the same set.
    always_comb
    begin
        s_axis_tready = (state_reg == salc_pkg::ST_IDLE);
        ram_we        = (state_reg == salc_pkg::ST_CLEAR) || (state_reg == salc_pkg::ST_WRITE);
        ram_waddr     = (state_reg == salc_pkg::ST_CLEAR) ? clr_cnt_reg : rem_reg[SETW-1:0];
        ram_wdata     = (state_reg == salc_pkg::ST_CLEAR) ? '0 : ROW_W'(wr_row);
    end

    // Datapath next values
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        sets_next      = sets_reg;
        ways_next      = ways_reg;
        access_next    = access_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        row_next       = row_reg;
        hit_next       = hit_reg;
        chosen_next    = chosen_reg;
        scan_next      = scan_reg;
        oldest_next    = oldest_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_SETS_IN_USE: sets_next = cfg_data;
                salc_pkg::CFG_WAYS_IN_USE: ways_next = cfg_data[salc_pkg::WAYS_REG_W-1:0];
                default:                   sets_next = sets_reg;
            endcase
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SETW'(1);
            end
            salc_pkg::ST_IDLE:
            begin
                addr_next    = s_axis_tdata[salc_pkg::ADDR_W-1:0];
                div_next     = salc_pkg::DIV_W'(s_axis_tdata[salc_pkg::ADDR_W-1:0]);
                rem_next     = '0;
                div_cnt_next = '0;
            end
            salc_pkg::ST_DIV:
            begin
                rem_next     = rem_step;
                div_next     = div_reg << salc_pkg::DIV_BITS;
                div_cnt_next = div_cnt_reg + salc_pkg::DIV_CNT_W'(1);
            end
            salc_pkg::ST_READ:
            begin
                row_next = row_reg;
            end
            salc_pkg::ST_LOOK:
            begin
                row_next    = rd_row;
                hit_next    = look_hit;
                scan_next   = WAYW'(1);
                oldest_next = rd_row[0].stamp;
                if (look_hit)
                begin
                    chosen_next = look_hit_way;
                end
                else if (look_empty)
                begin
                    chosen_next = look_empty_way;
                end
                else
                begin
                    chosen_next = '0;
                end
            end
            salc_pkg::ST_SCAN:
            begin
                // Strictly smaller only, so ties keep the lower way.
                if (row_reg[scan_reg].stamp < oldest_reg)
                begin
                    oldest_next = row_reg[scan_reg].stamp;
                    chosen_next = scan_reg;
                end
                scan_next = scan_reg + WAYW'(1);
            end
            salc_pkg::ST_WRITE:
            begin
                if (access_reg != '1)
                begin
                    access_next = access_reg + salc_pkg::COUNT_W'(1);
                end
                if (!hit_reg && miss_reg != '1)
                begin
                    miss_next = miss_reg + salc_pkg::COUNT_W'(1);
                end
            end
            salc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, miss_reg,
                                      salc_pkg::WAY_OUT_W'(chosen_reg), hit_reg};
                end
            end
            default:
            begin
                clr_cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= salc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            sets_reg      <= salc_pkg::SETS_RESET;
            ways_reg      <= salc_pkg::WAYS_RESET;
            access_reg    <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            sets_reg      <= sets_next;
            ways_reg      <= ways_next;
            access_reg    <= access_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        row_reg      <= row_next;
        hit_reg      <= hit_next;
        chosen_reg   <= chosen_next;
        scan_reg     <= scan_next;
        oldest_reg   <= oldest_next;
        out_data_reg <= out_data_next;
    end

    // One row per set holds every way's valid bit, tag and timestamp.
    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rem_reg[SETW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* hw/rtl/salc_checks.sv */
// Port-level assertions for the cache tag store, bound to its top level.
module salc_checks (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [salc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic                          seen_reg;
    logic [salc_pkg::COUNT_W-1:0]  last_miss_reg;
    logic                          out_fire;
    logic                          in_fire;
    logic [salc_pkg::COUNT_W-1:0]  cur_miss;

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cur_miss = m_axis_tdata[35:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_miss_reg <= '0;
        end
        else if (out_fire)
        begin
            seen_reg      <= 1'b1;
            last_miss_reg <= cur_miss;
        end
    end

    // A result that is offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second request accepted while one is in work");

    // A hit leaves the miss total unchanged; a miss adds one unless saturated.
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && seen_reg) |->
            ((m_axis_tdata[0] && cur_miss == last_miss_reg) ||
             (!m_axis_tdata[0] && cur_miss == last_miss_reg + salc_pkg::COUNT_W'(1)) ||
             (!m_axis_tdata[0] && last_miss_reg == '1 && cur_miss == '1)))
        else $error("miss total out of step with hit flag");

endmodule

bind set_assoc_lru_cache_tags salc_checks u_salc_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/lru_tag_checker.sv */
// Checker for the cache tag store: mirrors the registers, predicts each result and compares.
module lru_tag_checker #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [salc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [30:0] address
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [salc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [0] hit, [3:1] way,
                                                                // [35:4] misses
    output int                                   mismatches,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = MAX_SETS * MAX_WAYS;

    typedef struct packed {
        logic                           hit;
        logic [salc_pkg::WAY_OUT_W-1:0] way;
        logic [salc_pkg::COUNT_W-1:0]   misses;
    } lookup_t;

    logic                            tag_valid [ENTRIES];
    logic [salc_pkg::ADDR_W-1:0]     tag_addr  [ENTRIES];
    logic [salc_pkg::STAMP_W-1:0]    tag_stamp [ENTRIES];
    logic [salc_pkg::STAMP_W-1:0]    access_index;
    logic [salc_pkg::COUNT_W-1:0]    miss_total;
    logic [salc_pkg::SETS_REG_W-1:0] sets_reg;
    logic [salc_pkg::WAYS_REG_W-1:0] ways_reg;

    lookup_t predicted_lookups [$];
    lookup_t wanted;
    lookup_t seen;

    // Applies one access to the mirrored tag store and returns what the block should report.
    function automatic lookup_t access_tag_store(input logic [salc_pkg::ADDR_W-1:0] addr);
        int unsigned nsets;
        int unsigned nways;
        int unsigned base;
        int unsigned chosen;
        logic hit;
        logic placed;
        logic [salc_pkg::STAMP_W-1:0] oldest;
        lookup_t r;
        nsets = (sets_reg == '0) ? 1 : ((sets_reg > MAX_SETS) ? MAX_SETS : sets_reg);
        nways = (ways_reg == '0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
        base = (addr % nsets) * MAX_WAYS;
        hit = 1'b0;
        chosen = 0;
        for (int w = 0; w < nways; w++)
        begin
            if (!hit && tag_valid[base + w] && tag_addr[base + w] == addr)
            begin
                hit = 1'b1;
                chosen = w;
            end
        end
        if (hit)
        begin
            tag_stamp[base + chosen] = access_index;
        end
        else
        begin
            if (miss_total != '1)
                miss_total = miss_total + 1'b1;
            placed = 1'b0;
            for (int w = 0; w < nways; w++)
            begin
                if (!placed && !tag_valid[base + w])
                begin
                    placed = 1'b1;
                    chosen = w;
                end
            end
            // Full set: replace the least recently used way, lowest index on a tie.
            if (!placed)
            begin
                chosen = 0;
                oldest = tag_stamp[base];
                for (int w = 1; w < nways; w++)
                begin
                    if (tag_stamp[base + w] < oldest)
                    begin
                        oldest = tag_stamp[base + w];
                        chosen = w;
                    end
                end
            end
            tag_valid[base + chosen] = 1'b1;
            tag_addr[base + chosen]  = addr;
            tag_stamp[base + chosen] = access_index;
        end
        if (access_index != '1)
            access_index = access_index + 1'b1;
        r.hit    = hit;
        r.way    = chosen[salc_pkg::WAY_OUT_W-1:0];
        r.misses = miss_total;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input lookup_t exp_r, input lookup_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %m: %s: expected hit=%0d way=%0d misses=%0d, %s",
                     $realtime, what, exp_r.hit, exp_r.way, exp_r.misses,
                     $sformatf("got hit=%0d way=%0d misses=%0d",
                               got_r.hit, got_r.way, got_r.misses));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
                tag_valid[e] = 1'b0;
            access_index = '0;
            miss_total   = '0;
            sets_reg     = salc_pkg::SETS_RESET;
            ways_reg     = salc_pkg::WAYS_RESET;
            predicted_lookups.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == salc_pkg::CFG_SETS_IN_USE)
                    sets_reg = cfg_data[salc_pkg::SETS_REG_W-1:0];
                else if (cfg_index == salc_pkg::CFG_WAYS_IN_USE)
                    ways_reg = cfg_data[salc_pkg::WAYS_REG_W-1:0];
            end
            // Results always belong to earlier requests, so compare before predicting.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.hit    = m_axis_tdata[0];
                seen.way    = m_axis_tdata[3:1];
                seen.misses = m_axis_tdata[35:4];
                if (predicted_lookups.size() == 0)
                begin
                    note_mismatch("result with no request outstanding", '0, seen);
                end
                else
                begin
                    wanted = predicted_lookups.pop_front();
                    if (seen.hit != wanted.hit || seen.way != wanted.way
                        || seen.misses != wanted.misses)
                        note_mismatch("wrong result", wanted, seen);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_lookups.push_back(
                    access_tag_store(s_axis_tdata[salc_pkg::ADDR_W-1:0]));
            outstanding <= predicted_lookups.size();
        end
    end

endmodule

/* tb/set_assoc_lru_cache_tags_tb.sv */
// Testbench top for the cache tag store: clock, reset, request and register stimulus, verdict.
module set_assoc_lru_cache_tags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SETS       = 64;
    localparam int MAX_WAYS       = 8;
    localparam int ACCESSES_PER   = 130;   // random requests per register setting
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request or result moving
    localparam int DRAIN_CYCLES   = 40;
    localparam int MODE_SPAN      = 482;   // requests per idling mode

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index = salc_pkg::CFG_SETS_IN_USE;
    logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [salc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [salc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int issued = 0;
    int send_idle_pct = 37;
    int recv_idle_pct = 76;

    // Address shaping for the random part: a handful of tags folded onto a few hot sets,
    // so that the same lines come back often enough to hit and to force evictions.
    logic [salc_pkg::ADDR_W-1:0] tag_pool [MAX_WAYS + 3];
    int unsigned                 hot_sets [4];
    logic [salc_pkg::ADDR_W-1:0] last_addr = '0;

    set_assoc_lru_cache_tags #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lru_tag_checker #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) lru_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #1 clk = ~clk;

    // The result side stalls at random; the percentage follows the current idling mode.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Counts cycles in which neither a request nor a result is accepted. The clearing pass
    // after reset and the slowest request are far below the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("set_assoc_lru_cache_tags_tb: errors");
        $finish;
    end

    // Offers one access request and holds it until the block takes it. The idling mode moves
    // on with the number of requests issued: sender idles 37% and receiver 76% first, then
    // the other way round, then neither idles.
    task automatic push_request(input logic [salc_pkg::ADDR_W-1:0] addr);
        if (issued < MODE_SPAN)
        begin
            send_idle_pct = 37;
            recv_idle_pct = 76;
        end
        else if (issued < 2 * MODE_SPAN)
        begin
            send_idle_pct = 76;
            recv_idle_pct = 37;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(salc_pkg::IN_TDATA_W - salc_pkg::ADDR_W){1'b0}}, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        issued++;
    endtask

    // Drops valid and waits until every predicted result has been taken. The block finishes
    // its write-back before it hands a result over, so it is idle from then on.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One register setting followed by a burst of random requests. Register values outside
    // the legal ranges are written on purpose: zero acts as one, larger values saturate,
    // and only the low four bits of the ways register count. Stored lines survive a change.
    task automatic run_setting(input logic [salc_pkg::CFG_DATA_W-1:0] sets_val,
                               input logic [salc_pkg::CFG_DATA_W-1:0] ways_val,
                               input bit write_regs);
        int unsigned eff_sets;
        int unsigned eff_ways;
        int unsigned pick;
        int unsigned slot;
        logic [salc_pkg::ADDR_W-1:0] addr;
        if (write_regs)
        begin
            wait_for_drain();
            cfg_we    <= 1'b1;
            cfg_index <= salc_pkg::CFG_SETS_IN_USE;
            cfg_data  <= sets_val;
            @(posedge clk);
            cfg_index <= salc_pkg::CFG_WAYS_IN_USE;
            cfg_data  <= ways_val;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
        eff_sets = (sets_val == 0) ? 1 : ((sets_val > MAX_SETS) ? MAX_SETS : sets_val);
        eff_ways = (ways_val[3:0] == 0) ? 1
                 : ((ways_val[3:0] > MAX_WAYS) ? MAX_WAYS : ways_val[3:0]);
        for (int i = 0; i < eff_ways + 3; i++)
            tag_pool[i] = salc_pkg::ADDR_W'($urandom_range(0, 32'h7FFF_0000));
        for (int j = 0; j < 4; j++)
            hot_sets[j] = $urandom_range(0, eff_sets - 1);
        repeat (ACCESSES_PER)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // Anywhere in the address space, so every address bit moves.
                addr = salc_pkg::ADDR_W'($urandom);
            end
            else if (pick < 20)
            begin
                // Same line again: a hit, unless the register setting changed in between.
                addr = last_addr;
            end
            else
            begin
                // One of a few more tags than there are ways, aimed at a hot set.
                slot = $urandom_range(0, eff_ways + 2);
                addr = salc_pkg::ADDR_W'(tag_pool[slot] - tag_pool[slot] % eff_sets
                                         + hot_sets[$urandom_range(0, 3)]);
            end
            push_request(addr);
            last_addr = addr;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting (64 sets, 8 ways): the lowest and highest
        // addresses, a repeat of each to hit, then set 0 is filled past its eight ways so
        // that the least recently used line is evicted, and the evicted line comes back.
        push_request(salc_pkg::ADDR_W'(0));
        push_request(salc_pkg::ADDR_W'(31'h7FFF_FFFF));
        push_request(salc_pkg::ADDR_W'(0));
        push_request(salc_pkg::ADDR_W'(31'h7FFF_FFFF));
        for (int k = 1; k <= 8; k++)
            push_request(salc_pkg::ADDR_W'(k * MAX_SETS));
        push_request(salc_pkg::ADDR_W'(0));
        push_request(salc_pkg::ADDR_W'(MAX_SETS));
        push_request(salc_pkg::ADDR_W'(31'h2AAA_AAAA));
        push_request(salc_pkg::ADDR_W'(31'h5555_5555));
        last_addr = salc_pkg::ADDR_W'(31'h5555_5555);

        run_setting(7'd64, 7'd8, 1'b0);
        run_setting(7'd1, 7'd1, 1'b1);      // fully mapped onto one line
        run_setting(7'd1, 7'd8, 1'b1);      // one fully associative set
        run_setting(7'd3, 7'd2, 1'b1);
        run_setting(7'd0, 7'd0, 1'b1);      // zero in both registers acts as one
        run_setting(7'd127, 7'h7F, 1'b1);   // all ones in both: saturate to the maximum
        run_setting(7'd5, 7'd4, 1'b1);
        run_setting(7'd64, 7'd1, 1'b1);     // direct mapped
        run_setting(7'd7, 7'd3, 1'b1);
        run_setting(7'd2, 7'd12, 1'b1);     // ways above the maximum
        run_setting(7'd64, 7'd8, 1'b1);     // back to the reset setting

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("set_assoc_lru_cache_tags_tb: clean");
        else
            $display("set_assoc_lru_cache_tags_tb: errors");
        $finish;
    end

endmodule
